// File: sv/binary_min_heap_queue_macros.svh
// Assertion macros used by the binary min-heap queue top level.
`ifndef BINARY_MIN_HEAP_QUEUE_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define BMHQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define BMHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BMHQ_ASSERT_NOW(lbl, ante, cons, msg)
`define BMHQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/bmhq_pkg.sv
// Types and constants shared by the binary min-heap queue modules.
package bmhq_pkg;

  localparam int KEY_W        = 64;
  localparam int SRC_W        = 8;
  localparam int POS_W        = 32;
  localparam int DEF_CAPACITY = 64;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [SRC_W-1:0] source;
    logic [POS_W-1:0] position;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_push;
    logic    load_pop;
    logic    take_pop;
    logic    up_read;
    logic    up_move;
    logic    sink_read;
    logic    sink_move;
    logic    place;
    logic    finish;
    status_t code;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic up_go;
    logic has_child;
    logic sink_go;
  } stat_t;

endpackage

// File: sv/bmhq_datapath.sv
// Datapath of the heap queue: entry memory, counters, comparators and result registers.
module bmhq_datapath #(
  parameter int CAPACITY = bmhq_pkg::DEF_CAPACITY,
  localparam int OCC_W   = $clog2(CAPACITY + 1),
  localparam int IDX_W   = $clog2(CAPACITY)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [bmhq_pkg::KEY_W-1:0] key,
  input  logic [bmhq_pkg::SRC_W-1:0] source,
  input  logic [bmhq_pkg::POS_W-1:0] position,
  input  bmhq_pkg::ctrl_t            ctl,
  output bmhq_pkg::stat_t            st,
  output logic                       done,
  output logic [bmhq_pkg::KEY_W-1:0] min_key,
  output logic [bmhq_pkg::SRC_W-1:0] min_source,
  output logic [bmhq_pkg::POS_W-1:0] min_position,
  output bmhq_pkg::status_t          status,
  output logic [OCC_W-1:0]           occupancy
);
  import bmhq_pkg::*;

  localparam int CW = IDX_W + 1;

  entry_t mem [CAPACITY];

  logic [OCC_W-1:0] count;
  logic [IDX_W-1:0] slot;
  entry_t           mov;
  entry_t           res;
  entry_t           rd_a;
  entry_t           rd_b;

  logic [OCC_W-1:0] count_m1;
  logic [IDX_W-1:0] parent;
  logic [CW-1:0]    lc;
  logic [CW-1:0]    rc;
  logic [CW-1:0]    count_w;
  logic             rc_ok;
  logic             l_lt;
  logic             r_lt_m;
  logic             r_lt_l;
  logic             pick_right;
  logic [IDX_W-1:0] addr_a;
  logic [IDX_W-1:0] addr_b;
  logic             rd_en;
  logic             we;
  entry_t           wdata;

  assign count_m1 = count - OCC_W'(1);
  assign parent   = (slot - IDX_W'(1)) >> 1;
  assign lc       = {slot, 1'b1};
  assign rc       = lc + CW'(1);
  assign count_w  = CW'(count);
  assign rc_ok    = rc < count_w;

  // Children are compared with the moving entry and with each other in parallel.
  assign l_lt       = rd_a.key < mov.key;
  assign r_lt_m     = rd_b.key < mov.key;
  assign r_lt_l     = rd_b.key < rd_a.key;
  assign pick_right = rc_ok && (l_lt ? r_lt_l : r_lt_m);

  assign st.full      = count == OCC_W'(CAPACITY);
  assign st.empty     = count == '0;
  assign st.at_root   = slot == '0;
  assign st.up_go     = rd_a.key > mov.key;
  assign st.has_child = lc < count_w;
  assign st.sink_go   = l_lt || pick_right;

  always_comb begin
    addr_a = '0;
    addr_b = '0;
    if (ctl.load_pop) begin
      addr_b = count_m1[IDX_W-1:0];
    end else if (ctl.up_read) begin
      addr_a = parent;
    end else if (ctl.sink_read) begin
      addr_a = lc[IDX_W-1:0];
      addr_b = rc[IDX_W-1:0];
    end
  end

  assign rd_en = ctl.load_pop | ctl.up_read | ctl.sink_read;
  assign we    = ctl.place | ctl.up_move | ctl.sink_move;

  always_comb begin
    wdata = mov;
    if (ctl.up_move) begin
      wdata = rd_a;
    end else if (ctl.sink_move) begin
      wdata = pick_right ? rd_b : rd_a;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[slot] <= wdata;
    end
    if (rd_en) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= ctl.finish;
      if (ctl.load_push) begin
        count <= count + OCC_W'(1);
      end else if (ctl.load_pop) begin
        count <= count_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_push) begin
      mov  <= '{key: key, source: source, position: position};
      res  <= '0;
      slot <= count[IDX_W-1:0];
    end
    if (ctl.take_pop) begin
      res  <= rd_a;
      mov  <= rd_b;
      slot <= '0;
    end
    if (ctl.up_move) begin
      slot <= parent;
    end
    if (ctl.sink_move) begin
      slot <= pick_right ? rc[IDX_W-1:0] : lc[IDX_W-1:0];
    end
    if (ctl.finish) begin
      status    <= ctl.code;
      occupancy <= count;
      if (ctl.code == ST_OK) begin
        min_key      <= res.key;
        min_source   <= res.source;
        min_position <= res.position;
      end else begin
        min_key      <= '0;
        min_source   <= '0;
        min_position <= '0;
      end
    end
  end

endmodule

// File: sv/bmhq_ctrl.sv
// Controller state machine that sequences pushes, pops and the sift steps.
module bmhq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            command,
  input  bmhq_pkg::stat_t st,
  output logic            busy,
  output bmhq_pkg::ctrl_t ctl
);
  import bmhq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_UP_CHK  = 6'b000010,
    S_UP_CMP  = 6'b000100,
    S_POP_CAP = 6'b001000,
    S_DN_CHK  = 6'b010000,
    S_DN_CMP  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = state != S_IDLE;

  always_comb begin
    ctl        = '0;
    ctl.code   = ST_OK;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (command == CMD_PUSH) begin
            if (st.full) begin
              ctl.finish = 1'b1;
              ctl.code   = ST_FULL;
            end else begin
              ctl.load_push = 1'b1;
              state_next    = S_UP_CHK;
            end
          end else begin
            if (st.empty) begin
              ctl.finish = 1'b1;
              ctl.code   = ST_EMPTY;
            end else begin
              ctl.load_pop = 1'b1;
              state_next   = S_POP_CAP;
            end
          end
        end
      end
      S_UP_CHK: begin
        if (st.at_root) begin
          ctl.place  = 1'b1;
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          ctl.up_read = 1'b1;
          state_next  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (st.up_go) begin
          ctl.up_move = 1'b1;
          state_next  = S_UP_CHK;
        end else begin
          ctl.place  = 1'b1;
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_POP_CAP: begin
        ctl.take_pop = 1'b1;
        state_next   = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (st.has_child) begin
          ctl.sink_read = 1'b1;
          state_next    = S_DN_CMP;
        end else begin
          ctl.place  = 1'b1;
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DN_CMP: begin
        if (st.sink_go) begin
          ctl.sink_move = 1'b1;
          state_next    = S_DN_CHK;
        end else begin
          ctl.place  = 1'b1;
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: sv/binary_min_heap_queue.sv
// Top level of the binary min-heap priority queue.
//
// A binary min-heap of up to CAPACITY entries, each a 64-bit unsigned key with
// an 8-bit source tag and a 32-bit position tag. A beat is taken when start is
// high and busy is low; command selects a push of key, source and position or
// a pop of the smallest entry. Every beat produces exactly one result beat,
// shown for a single cycle with done high; the receiver cannot hold it off,
// so it must capture the result in that cycle. A refused push on a full heap
// or a pop on an empty heap returns its status in the cycle after the beat,
// with zero key and tags and busy never raised. A push climbs one level at a
// time, reading the parent and moving it down while its key is greater, and
// writes the entry into its slot when it reaches the root or a parent stops
// it. A pop reads the root and the last entry, takes the root as its result,
// then sinks that entry one level at a time, reading both children and moving
// the chosen one up, and writes the entry when it ends on a slot without
// children or when neither child is smaller. With the default capacity of 64
// the longest push is one into the last free slot that climbs all six levels
// to the root. Each level of a sift needs one registered read and then one
// compare and write, through one write port and two read ports of the entry
// memory. Equal keys never pass each other while rising, and a sinking entry
// moves to the strictly smaller child, taking the left one when the two
// children tie. Occupancy gives the number of entries held after the operation.
module binary_min_heap_queue #(
  parameter int CAPACITY = bmhq_pkg::DEF_CAPACITY,
  localparam int OCC_W   = $clog2(CAPACITY + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       command,
  input  logic [bmhq_pkg::KEY_W-1:0] key,
  input  logic [bmhq_pkg::SRC_W-1:0] source,
  input  logic [bmhq_pkg::POS_W-1:0] position,
  output logic                       done,
  output logic [bmhq_pkg::KEY_W-1:0] min_key,
  output logic [bmhq_pkg::SRC_W-1:0] min_source,
  output logic [bmhq_pkg::POS_W-1:0] min_position,
  output bmhq_pkg::status_t          status,
  output logic [OCC_W-1:0]           occupancy
);
  import bmhq_pkg::*;

`include "binary_min_heap_queue_macros.svh"

  ctrl_t ctl;
  stat_t st;

  // The controller holds only its state and decides the sequence of steps; the
  // datapath owns all other storage and reports only comparison and bound flags.
  bmhq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .st      (st),
    .busy    (busy),
    .ctl     (ctl)
  );

  bmhq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .key          (key),
    .source       (source),
    .position     (position),
    .ctl          (ctl),
    .st           (st),
    .done         (done),
    .min_key      (min_key),
    .min_source   (min_source),
    .min_position (min_position),
    .status       (status),
    .occupancy    (occupancy)
  );

  // An accepted beat either starts an operation that raises busy or is answered with done.
  `BMHQ_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "accepted beat dropped")
  // The heap can never report more entries than its capacity.
  `BMHQ_ASSERT_NOW(a_occ_bound, done, occupancy <= OCC_W'(CAPACITY), "occupancy beyond capacity")
  // Refused operations carry no entry.
  `BMHQ_ASSERT_NOW(a_err_zero, done && status != ST_OK, min_key == '0, "refused beat has a key")
  // A refused push only happens at full capacity.
  `BMHQ_ASSERT_NOW(a_full_occ, done && status == ST_FULL, st.full, "full status below capacity")

endmodule
